### hw/rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared constants, types and the sample pre-divide for the touch sample
// calibrate block.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // Fixed design constants
  localparam int SAMPLE_DIV = 1;
  localparam int ADC_MAX_X  = 4095;
  localparam int ADC_MAX_Y  = 4095;
  localparam int COEF_SCALE = 65536;
  localparam int SCREEN_W   = 320;
  localparam int SCREEN_H   = 240;

  // Field and datapath widths
  localparam int SAMPLE_W = 12;
  localparam int EXTRA_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int COORD_W  = 10;
  localparam int COEF_W   = 32;
  localparam int COEF_N   = 6;
  localparam int IX_W     = SAMPLE_W + 1;
  localparam int PROD_W   = IX_W + COEF_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int REM_W    = 31;

  // Stream data widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * COORD_W;

  // Configuration port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_EXTRA  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_C = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_D = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEF_E = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_COEF_F = 3'd6;

  // Slots in the coefficient bank
  localparam int COEF_A_SEL = 0;
  localparam int COEF_B_SEL = 1;
  localparam int COEF_C_SEL = 2;
  localparam int COEF_D_SEL = 3;
  localparam int COEF_E_SEL = 4;
  localparam int COEF_F_SEL = 5;

  // Burst queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Reciprocal for the sample pre-divide
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = (1 << RECIP_SHIFT) / SAMPLE_DIV;
  localparam int RECIP_PW    = SAMPLE_W + RECIP_SHIFT + 1;
  localparam int RECIP_RW    = SAMPLE_W + 5;

  // Reciprocal for the divide by COEF_SCALE. The dividend is below
  // 2**COORD_W * COEF_SCALE, so this shift keeps the estimate within one of
  // the true quotient and a single correction step finishes it.
  localparam int     QDIV_SHIFT = $clog2(COEF_SCALE) + COORD_W + 1;
  localparam longint QDIV_RECIP = (longint'(1) << QDIV_SHIFT) / COEF_SCALE;
  localparam int     QDIV_RW    = COORD_W + 3;
  localparam int     QDIV_PW    = REM_W + QDIV_RW;

  typedef logic [COEF_N-1:0][COEF_W-1:0] coef_bank_t;

  // One finished burst handed from the front to the back
  typedef struct packed {
    logic                touch;
    logic [SAMPLE_W-1:0] avg_y;
    logic [SAMPLE_W-1:0] avg_x;
  } burst_t;

  // Sample divided by SAMPLE_DIV: reciprocal multiply, then one correction step
  function automatic logic [SAMPLE_W-1:0] div_sample(input logic [SAMPLE_W-1:0] v);
    logic [RECIP_PW-1:0] prod;
    logic [SAMPLE_W-1:0] q0;
    logic [RECIP_RW-1:0] qd;
    logic [RECIP_RW-1:0] r;
    prod = RECIP_PW'(v) * RECIP_PW'(RECIP);
    q0   = prod[RECIP_SHIFT +: SAMPLE_W];
    qd   = RECIP_RW'(q0) * RECIP_RW'(SAMPLE_DIV);
    r    = RECIP_RW'(v) - qd;
    if (r >= RECIP_RW'(SAMPLE_DIV)) begin
      return q0 + 1'b1;
    end
    return q0;
  endfunction

endpackage

### hw/rtl/tsc_front.sv
// ----------------------------------------------------------------------------
// tsc_front
// Accepts raw samples, keeps the running average and burst count, and pushes
// one entry into the burst queue at the end of every burst.
// ----------------------------------------------------------------------------
module tsc_front import tsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // raw_x, raw_y
  input  logic [EXTRA_W-1:0]    extra_samples,
  input  logic                  q_full,
  output logic                  push,
  output burst_t                entry
);

  logic [SAMPLE_W-1:0] avg_x;
  logic [SAMPLE_W-1:0] avg_y;
  logic [COUNT_W-1:0]  burst_count;

  logic [SAMPLE_W-1:0] avg_x_next;
  logic [SAMPLE_W-1:0] avg_y_next;
  logic [COUNT_W-1:0]  burst_count_next;

  logic [SAMPLE_W-1:0] div_x;
  logic [SAMPLE_W-1:0] div_y;
  logic [SAMPLE_W-1:0] smp_x;
  logic [SAMPLE_W-1:0] smp_y;
  logic [SAMPLE_W:0]   sum_x;
  logic [SAMPLE_W:0]   sum_y;
  logic                accept;
  logic                burst_end;
  logic                touch;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign div_x = div_sample(s_tdata[SAMPLE_W-1:0]);
  assign div_y = div_sample(s_tdata[2*SAMPLE_W-1:SAMPLE_W]);

  // Pen up on either axis zeroes both
  assign smp_x = (div_x == '0 || div_y == '0) ? '0 : div_x;
  assign smp_y = (div_x == '0 || div_y == '0) ? '0 : div_y;

  assign sum_x = {1'b0, avg_x} + {1'b0, smp_x};
  assign sum_y = {1'b0, avg_y} + {1'b0, smp_y};

  always_comb begin
    priority if (burst_count == '0) begin
      avg_x_next       = smp_x;
      avg_y_next       = smp_y;
      burst_end        = (extra_samples == '0);
      burst_count_next = burst_end ? '0 : COUNT_W'(1);
      touch            = (smp_x != '0);
    end else if (smp_x == '0) begin
      // Pen lifted mid-burst: end now, no touch
      avg_x_next       = '0;
      avg_y_next       = '0;
      burst_end        = 1'b1;
      burst_count_next = '0;
      touch            = 1'b0;
    end else begin
      avg_x_next       = sum_x[SAMPLE_W:1];
      avg_y_next       = sum_y[SAMPLE_W:1];
      burst_end        = (burst_count >= {1'b0, extra_samples});
      burst_count_next = burst_end ? '0 : burst_count + 1'b1;
      touch            = (sum_x[SAMPLE_W:1] != '0);
    end
  end

  assign push        = accept && burst_end;
  assign entry.touch = touch;
  assign entry.avg_x = avg_x_next;
  assign entry.avg_y = avg_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_x       <= '0;
      avg_y       <= '0;
      burst_count <= '0;
    end else if (accept) begin
      avg_x       <= avg_x_next;
      avg_y       <= avg_y_next;
      burst_count <= burst_count_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    burst_count[COUNT_W-1] == 1'b0)
    else $error("burst count left the 8-bit range");

  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> (s_tvalid && !q_full))
    else $error("burst pushed without an accepted sample");

  a_touch_nonzero: assert property (@(posedge clk) disable iff (rst)
    (push && entry.touch) |-> (entry.avg_x != '0))
    else $error("touch flagged with a zero x average");
`endif

endmodule

### hw/rtl/tsc_queue.sv
// ----------------------------------------------------------------------------
// tsc_queue
// Short FIFO of finished bursts between the front and the back.
// ----------------------------------------------------------------------------
module tsc_queue import tsc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  burst_t wr_entry,
  output logic   full,
  input  logic   pop,
  output burst_t rd_entry,
  output logic   empty
);

  burst_t          mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign full     = (count == Q_CW'(Q_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("burst queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("burst queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("burst queue count out of range");
`endif

endmodule

### hw/rtl/tsc_back.sv
// ----------------------------------------------------------------------------
// tsc_back
// Inverts the burst average, applies the affine transform, range checks it and
// divides by the coefficient scale with a reciprocal multiply and one
// correction step.
// ----------------------------------------------------------------------------
module tsc_back import tsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  coef_bank_t             coef,
  input  logic                   q_empty,
  input  burst_t                 q_entry,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // screen_x, screen_y, zero pad
  output logic                   m_tuser   // pen_down
);

  localparam logic signed [SUM_W-1:0] LIM_X = SUM_W'(SCREEN_W * COEF_SCALE);
  localparam logic signed [SUM_W-1:0] LIM_Y = SUM_W'(SCREEN_H * COEF_SCALE);
  localparam logic signed [SUM_W-1:0] NEG_K = SUM_W'(-COEF_SCALE);

  localparam logic [QDIV_RW-1:0] RECIP_K = QDIV_RW'(QDIV_RECIP);
  localparam logic [REM_W-1:0]   K_REM   = REM_W'(COEF_SCALE);

  logic en;

  // Stage 1: inverted averages
  logic                   s1_vld;
  logic                   s1_touch;
  logic signed [IX_W-1:0] s1_ix;
  logic signed [IX_W-1:0] s1_iy;

  // Stage 2: products
  logic                     s2_vld;
  logic                     s2_touch;
  logic signed [PROD_W-1:0] s2_pax;
  logic signed [PROD_W-1:0] s2_pbx;
  logic signed [PROD_W-1:0] s2_pdy;
  logic signed [PROD_W-1:0] s2_pey;

  // Stage 3: scaled sums
  logic                    s3_vld;
  logic                    s3_touch;
  logic signed [SUM_W-1:0] s3_sx;
  logic signed [SUM_W-1:0] s3_sy;

  logic ok_x;
  logic ok_y;
  logic pen_c;

  // Stage 4: range-checked dividends
  logic             d_vld;
  logic             d_pen;
  logic [REM_W-1:0] d_remx;
  logic [REM_W-1:0] d_remy;

  // Stage 5: quotient estimates
  logic               e_vld;
  logic               e_pen;
  logic [REM_W-1:0]   e_remx;
  logic [REM_W-1:0]   e_remy;
  logic [COORD_W-1:0] e_qx;
  logic [COORD_W-1:0] e_qy;

  // Output stage: corrected quotients
  logic               o_vld;
  logic               o_pen;
  logic [COORD_W-1:0] o_qx;
  logic [COORD_W-1:0] o_qy;

  logic [QDIV_PW-1:0] prod_x;
  logic [QDIV_PW-1:0] prod_y;
  logic [REM_W-1:0]   res_x;
  logic [REM_W-1:0]   res_y;

  // Whole pipeline advances unless the output holds a result not yet taken
  assign en  = !o_vld || m_tready;
  assign pop = en && !q_empty;

  // A negative sum above -COEF_SCALE truncates to zero, which is on screen
  assign ok_x  = s3_sx[SUM_W-1] ? (s3_sx > NEG_K) : (s3_sx < LIM_X);
  assign ok_y  = s3_sy[SUM_W-1] ? (s3_sy > NEG_K) : (s3_sy < LIM_Y);
  assign pen_c = s3_touch && ok_x && ok_y;

  // Quotient estimate is the true quotient or one below it
  assign prod_x = QDIV_PW'(d_remx) * QDIV_PW'(RECIP_K);
  assign prod_y = QDIV_PW'(d_remy) * QDIV_PW'(RECIP_K);

  assign res_x = e_remx - REM_W'(e_qx) * K_REM;
  assign res_y = e_remy - REM_W'(e_qy) * K_REM;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      d_vld  <= 1'b0;
      e_vld  <= 1'b0;
      o_vld  <= 1'b0;
    end else if (en) begin
      s1_vld <= pop;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      d_vld  <= s3_vld;
      e_vld  <= d_vld;
      o_vld  <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_touch <= q_entry.touch;
      s1_ix    <= IX_W'(ADC_MAX_X) - {1'b0, q_entry.avg_x};
      s1_iy    <= IX_W'(ADC_MAX_Y) - {1'b0, q_entry.avg_y};

      s2_touch <= s1_touch;
      s2_pax   <= $signed(coef[COEF_A_SEL]) * s1_ix;
      s2_pbx   <= $signed(coef[COEF_B_SEL]) * s1_iy;
      s2_pdy   <= $signed(coef[COEF_D_SEL]) * s1_ix;
      s2_pey   <= $signed(coef[COEF_E_SEL]) * s1_iy;

      s3_touch <= s2_touch;
      s3_sx    <= SUM_W'(s2_pax) + SUM_W'(s2_pbx) + SUM_W'($signed(coef[COEF_C_SEL]));
      s3_sy    <= SUM_W'(s2_pdy) + SUM_W'(s2_pey) + SUM_W'($signed(coef[COEF_F_SEL]));

      // Anything off screen or without touch enters the divider as zero
      d_pen  <= pen_c;
      d_remx <= (pen_c && !s3_sx[SUM_W-1]) ? s3_sx[REM_W-1:0] : '0;
      d_remy <= (pen_c && !s3_sy[SUM_W-1]) ? s3_sy[REM_W-1:0] : '0;

      e_pen  <= d_pen;
      e_remx <= d_remx;
      e_remy <= d_remy;
      e_qx   <= prod_x[QDIV_SHIFT +: COORD_W];
      e_qy   <= prod_y[QDIV_SHIFT +: COORD_W];

      // Bump the estimate when a whole divisor is still left over
      o_pen <= e_pen;
      o_qx  <= (res_x >= K_REM) ? e_qx + 1'b1 : e_qx;
      o_qy  <= (res_y >= K_REM) ? e_qy + 1'b1 : e_qy;
    end
  end

  assign m_tvalid = o_vld;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, o_qy, o_qx};
  assign m_tuser  = o_pen;

`ifndef ASSERT_OFF
  a_no_pen_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("result without pen_down carries nonzero coordinates");

  a_x_on_screen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, o_qx} < (COORD_W + 1)'(SCREEN_W)))
    else $error("screen_x beyond screen width");

  a_y_on_screen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, o_qy} < (COORD_W + 1)'(SCREEN_H)))
    else $error("screen_y beyond screen height");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(s1_vld) && $stable(s3_vld) && $stable(o_vld)))
    else $error("pipeline moved while output stalled");
`endif

endmodule

### hw/rtl/touch_sample_calibrate_core.sv
// ----------------------------------------------------------------------------
// touch_sample_calibrate_core
// Path from the edge accepting a burst's last sample to the result: burst queue,
// then invert, multiply, sum, range check, quotient estimate, correction.
// Throughput: one sample per cycle in, one result per cycle out; a stalled
// output holds the back, and the input stalls once the 4-entry queue fills.
// Reset clears configuration, burst state, queue pointers and pipeline valids.
// ----------------------------------------------------------------------------
module touch_sample_calibrate_core import tsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,

  // Raw sample stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [11:0] raw_x, [23:12] raw_y

  // Calibrated coordinate stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [9:0] screen_x, [19:10] screen_y, pad
  output logic                   m_tuser,   // [0] pen_down

  // Register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  // Configuration registers
  logic [EXTRA_W-1:0]   extra_samples;
  coef_bank_t           coef;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;

  // Front to queue, queue to back
  logic   push;
  logic   q_full;
  logic   q_empty;
  logic   pop;
  burst_t wr_entry;
  burst_t rd_entry;

  // --------------------------------------------------------------------------
  // Register port: word-aligned, index taken from paddr[4:2]; an index past
  // the last coefficient is dropped on write and reads as zero.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      extra_samples <= '0;
      coef          <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_EXTRA:  extra_samples          <= pwdata[EXTRA_W-1:0];
        REG_COEF_A: coef[COEF_A_SEL]       <= pwdata;
        REG_COEF_B: coef[COEF_B_SEL]       <= pwdata;
        REG_COEF_C: coef[COEF_C_SEL]       <= pwdata;
        REG_COEF_D: coef[COEF_D_SEL]       <= pwdata;
        REG_COEF_E: coef[COEF_E_SEL]       <= pwdata;
        REG_COEF_F: coef[COEF_F_SEL]       <= pwdata;
        default:    extra_samples          <= extra_samples;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EXTRA:  prdata = {{(DATA_W - EXTRA_W){1'b0}}, extra_samples};
      REG_COEF_A: prdata = coef[COEF_A_SEL];
      REG_COEF_B: prdata = coef[COEF_B_SEL];
      REG_COEF_C: prdata = coef[COEF_C_SEL];
      REG_COEF_D: prdata = coef[COEF_D_SEL];
      REG_COEF_E: prdata = coef[COEF_E_SEL];
      REG_COEF_F: prdata = coef[COEF_F_SEL];
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front: averages each burst and pushes one entry per finished burst. It
  // keeps taking samples while the back is stalled, until the queue fills.
  // --------------------------------------------------------------------------
  tsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .extra_samples (extra_samples),
    .q_full        (q_full),
    .push          (push),
    .entry         (wr_entry)
  );

  // --------------------------------------------------------------------------
  // Queue: decouples burst completion from the output handshake.
  // --------------------------------------------------------------------------
  tsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (pop),
    .rd_entry (rd_entry),
    .empty    (q_empty)
  );

  // --------------------------------------------------------------------------
  // Back: invert, multiply, sum, range check, then divide by the scale with a
  // reciprocal multiply and one correction step.
  // The whole pipeline holds while a result waits on m_tready.
  // --------------------------------------------------------------------------
  tsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .coef     (coef),
    .q_empty  (q_empty),
    .q_entry  (rd_entry),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### tb/touch_sample_calibrate_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_calibrate_core_tb
// Drives raw touch sample pairs into the core and programs the burst length
// and the six calibration weights over the register port. A burst tracker
// running alongside averages each burst and applies the affine map. The
// scoreboard checks every calibrated coordinate against it, in order. A short
// table of corner cases runs first, then randomized phases with input gaps,
// output stalls, a long output hold-off and a gap-free stretch.
// ----------------------------------------------------------------------------
module touch_sample_calibrate_core_tb;
  import tsc_pkg::*;

  // Byte address 28 decodes to an index past the last coefficient
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Leave ample margin beyond the output latency before touching registers
  localparam int DRAIN_CYCLES = 40;
  // Output hold-off long enough to back the burst queue up into the input
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
    logic               pen_down;
  } coord_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // One row of the directed table: a register write, or a sample that may
  // carry a hand-computed coordinate
  typedef struct packed {
    row_kind_t             kind;
    logic [REG_IDX_W-1:0]  idx;
    logic [DATA_W-1:0]     value;
    logic [SAMPLE_W-1:0]   raw_x;
    logic [SAMPLE_W-1:0]   raw_y;
    logic                  typed;
    coord_t                want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [11:0] raw_x, [23:12] raw_y
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [9:0] screen_x, [19:10] screen_y, pad
  logic                   m_tuser;   // [0] pen_down
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]      pwdata;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  touch_sample_calibrate_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the register file
  logic [EXTRA_W-1:0]  cfg_extra = '0;
  longint              cfg_coef [COEF_N];

  // Burst tracker state
  logic [SAMPLE_W-1:0] trk_avg_x = '0;
  logic [SAMPLE_W-1:0] trk_avg_y = '0;
  logic [COUNT_W-1:0]  trk_count = '0;

  coord_t    coord_q [$];   // coordinates owed by the core, oldest first
  plan_row_t plan [$];
  coord_t    got_c;
  coord_t    want_c;

  int src_gap_pct    = 33;
  int sink_stall_pct = 33;
  bit hold_req       = 1'b0;

  int n_fail     = 0;
  int n_samples  = 0;
  int n_coords   = 0;
  int n_touch    = 0;
  int n_writes   = 0;

  // Map the finished burst average onto the screen. Division truncates toward
  // zero, so a slightly negative sum still lands on coordinate zero.
  function automatic coord_t burst_coord();
    longint ix, iy, px, py;
    coord_t c;
    c = '0;
    if (trk_avg_x == '0) return c;   // no touch: skip the transform
    ix = longint'(ADC_MAX_X) - longint'(trk_avg_x);
    iy = longint'(ADC_MAX_Y) - longint'(trk_avg_y);
    px = (cfg_coef[COEF_A_SEL] * ix + cfg_coef[COEF_B_SEL] * iy + cfg_coef[COEF_C_SEL])
         / longint'(COEF_SCALE);
    py = (cfg_coef[COEF_D_SEL] * ix + cfg_coef[COEF_E_SEL] * iy + cfg_coef[COEF_F_SEL])
         / longint'(COEF_SCALE);
    if (px < 0 || px >= SCREEN_W || py < 0 || py >= SCREEN_H) return c;
    c.screen_x = px[COORD_W-1:0];
    c.screen_y = py[COORD_W-1:0];
    c.pen_down = 1'b1;
    return c;
  endfunction

  // Advance the burst tracker by one accepted sample
  task automatic track_sample(input logic [SAMPLE_W-1:0] rx, input logic [SAMPLE_W-1:0] ry,
                              output bit emitted, output coord_t res);
    logic [SAMPLE_W-1:0] sx, sy;
    sx = SAMPLE_W'(rx / SAMPLE_DIV);
    sy = SAMPLE_W'(ry / SAMPLE_DIV);
    // Pen up on either axis counts as pen up on both
    if (sx == '0 || sy == '0) begin
      sx = '0;
      sy = '0;
    end
    emitted = 1'b0;
    res     = '0;
    if (trk_count == '0) begin
      // First sample seeds the average, even when it is zero
      trk_avg_x = sx;
      trk_avg_y = sy;
      if (cfg_extra == '0) begin
        emitted = 1'b1;
        res     = burst_coord();
      end else begin
        trk_count = COUNT_W'(1);
      end
    end else if (sx == '0) begin
      // Pen lifted mid-burst: end it now with no touch
      trk_avg_x = '0;
      trk_avg_y = '0;
      trk_count = '0;
      emitted   = 1'b1;
    end else begin
      trk_avg_x = SAMPLE_W'(({1'b0, trk_avg_x} + {1'b0, sx}) >> 1);
      trk_avg_y = SAMPLE_W'(({1'b0, trk_avg_y} + {1'b0, sy}) >> 1);
      // Compare with >= so a lowered burst length ends the burst at once
      if (trk_count >= COUNT_W'(cfg_extra)) begin
        trk_count = '0;
        emitted   = 1'b1;
        res       = burst_coord();
      end else begin
        trk_count = trk_count + 1'b1;
      end
    end
  endtask

  // Register write: setup then access phase. Call and return at a falling edge.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    n_writes++;
    if (idx == REG_EXTRA) begin
      cfg_extra = value[EXTRA_W-1:0];
    end else if (idx >= REG_COEF_A && idx <= REG_COEF_F) begin
      cfg_coef[idx - REG_COEF_A] = longint'($signed(value));
    end
  endtask

  // Offer one sample, idling first at random. Returns at the falling edge after
  // the transaction with tvalid still high, so a following sample rides on.
  task automatic send_sample(input logic [SAMPLE_W-1:0] rx, input logic [SAMPLE_W-1:0] ry,
                             input logic typed, input coord_t want);
    bit     emitted;
    coord_t pred;
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {ry, rx};
    do @(posedge clk); while (!s_tready);
    n_samples++;
    track_sample(rx, ry, emitted, pred);
    // Hand-computed rows stand on their own instead of trusting the tracker
    if (emitted) coord_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed coordinate, then let the pipeline settle
  // so a burst still in flight cannot meet a register write
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (coord_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Plausible calibration: full ADC span onto the screen, jittered, with
  // offsets that push some touches off the edges
  task automatic load_fit();
    write_reg(REG_COEF_A, 5120 + int'($urandom_range(160)) - 80);
    write_reg(REG_COEF_B, int'($urandom_range(200)) - 100);
    write_reg(REG_COEF_C, int'($urandom_range(40 * 65536)) - 20 * 65536);
    write_reg(REG_COEF_D, int'($urandom_range(200)) - 100);
    write_reg(REG_COEF_E, 3840 + int'($urandom_range(120)) - 60);
    write_reg(REG_COEF_F, int'($urandom_range(30 * 65536)) - 15 * 65536);
  endtask

  task automatic run_phase(input int n_items, input int zero_pct);
    logic [SAMPLE_W-1:0] rx, ry;
    coord_t              none;
    none = '0;
    for (int k = 0; k < n_items; k++) begin
      rx = SAMPLE_W'($urandom_range(4095, 1));
      ry = SAMPLE_W'($urandom_range(4095, 1));
      // Pull toward the rails now and then
      if ($urandom_range(99) < 5) rx = $urandom_range(1) ? 12'd1 : 12'd4095;
      if ($urandom_range(99) < 5) ry = $urandom_range(1) ? 12'd1 : 12'd4095;
      // Pen up on one axis or both
      if ($urandom_range(99) < zero_pct) begin
        case ($urandom_range(2))
          0: rx = '0;
          1: ry = '0;
          default: begin
            rx = '0;
            ry = '0;
          end
        endcase
      end
      send_sample(rx, ry, 1'b0, none);
    end
  endtask

  function automatic void plan_write(input logic [REG_IDX_W-1:0] idx,
                                     input logic [DATA_W-1:0] value);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = value;
    plan.push_back(r);
  endfunction

  function automatic void plan_item(input logic [SAMPLE_W-1:0] rx, input logic [SAMPLE_W-1:0] ry,
                                    input logic typed, input int sx, input int sy,
                                    input logic pen);
    plan_row_t r;
    r                 = '0;
    r.kind            = ROW_SAMPLE;
    r.raw_x           = rx;
    r.raw_y           = ry;
    r.typed           = typed;
    r.want.screen_x   = COORD_W'(sx);
    r.want.screen_y   = COORD_W'(sy);
    r.want.pen_down   = pen;
    plan.push_back(r);
  endfunction

  // Output side: random stalls, plus a long hold-off on request counted here
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Scoreboard: check each output transaction against the oldest owed coordinate
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_c.screen_x = m_tdata[COORD_W-1:0];
      got_c.screen_y = m_tdata[2*COORD_W-1:COORD_W];
      got_c.pen_down = m_tuser;
      n_coords++;
      if (got_c.pen_down === 1'b1) n_touch++;
      if (coord_q.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected coordinate: expected none, got x=%0d y=%0d pen=%0d",
                 $time, got_c.screen_x, got_c.screen_y, got_c.pen_down);
      end else begin
        want_c = coord_q.pop_front();
        if (got_c.screen_x !== want_c.screen_x || got_c.screen_y !== want_c.screen_y ||
            got_c.pen_down !== want_c.pen_down) begin
          n_fail++;
          $display("%0t: coordinate mismatch: expected x=%0d y=%0d pen=%0d, got x=%0d y=%0d pen=%0d",
                   $time, want_c.screen_x, want_c.screen_y, want_c.pen_down,
                   got_c.screen_x, got_c.screen_y, got_c.pen_down);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("touch_sample_calibrate_core: mismatch");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    for (int k = 0; k < COEF_N; k++) cfg_coef[k] = 0;

    // Reset values: one sample per burst, all weights zero, so any touch maps
    // to the origin with pen down
    plan_item(12'd100,  12'd200,  1'b1, 0, 0, 1'b1);
    plan_item(12'd0,    12'd0,    1'b1, 0, 0, 1'b0);
    plan_item(12'd4095, 12'd0,    1'b1, 0, 0, 1'b0);
    plan_item(12'd0,    12'd4095, 1'b1, 0, 0, 1'b0);
    // Nominal fit: full scale lands on the far screen corner
    plan_write(REG_COEF_A, 32'd5120);
    plan_write(REG_COEF_E, 32'd3840);
    plan_item(12'd4095, 12'd4095, 1'b1, 0,   0,   1'b1);
    plan_item(12'd1,    12'd1,    1'b1, 319, 239, 1'b1);
    plan_item(12'd2048, 12'd1024, 1'b0, 0,   0,   1'b0);
    // One pixel of x offset pushes the corner off screen
    plan_write(REG_COEF_C, 32'd65536);
    plan_item(12'd1,    12'd1,    1'b1, 0, 0, 1'b0);
    // Most negative offset: x far below zero
    plan_write(REG_COEF_C, 32'h8000_0000);
    plan_item(12'd3000, 12'd3000, 1'b1, 0, 0, 1'b0);
    // Most positive offset: y far past the bottom edge
    plan_write(REG_COEF_C, 32'd0);
    plan_write(REG_COEF_F, 32'h7FFF_FFFF);
    plan_item(12'd100,  12'd100,  1'b1, 0, 0, 1'b0);
    // Cross terms
    plan_write(REG_COEF_F, 32'd0);
    plan_write(REG_COEF_B, 32'd1024);
    plan_write(REG_COEF_D, 32'hFFFF_FE00);
    plan_item(12'd500,  12'd3500, 1'b0, 0, 0, 1'b0);
    // Sum of -1 must truncate to zero, not round down to -1
    plan_write(REG_COEF_A, 32'hFFFF_FFFF);
    plan_write(REG_COEF_B, 32'd0);
    plan_write(REG_COEF_D, 32'd0);
    plan_write(REG_COEF_E, 32'd0);
    plan_item(12'd4094, 12'd4094, 1'b1, 0, 0, 1'b1);
    // Write past the last coefficient must land nowhere
    plan_write(REG_SPARE, 32'h7FFF_FFFF);
    plan_item(12'd4094, 12'd4094, 1'b1, 0, 0, 1'b1);
    plan_write(REG_COEF_A, 32'd5120);
    plan_write(REG_COEF_E, 32'd3840);
    // Three-sample bursts: zero first sample still seeds the average
    plan_write(REG_EXTRA, 32'd2);
    plan_item(12'd0,    12'd0,    1'b0, 0, 0, 1'b0);
    plan_item(12'd2000, 12'd2000, 1'b0, 0, 0, 1'b0);
    plan_item(12'd2000, 12'd2000, 1'b0, 0, 0, 1'b0);
    // Pen lifted on x, then on y alone, ends the burst early
    plan_item(12'd1000, 12'd1000, 1'b0, 0, 0, 1'b0);
    plan_item(12'd0,    12'd5,    1'b1, 0, 0, 1'b0);
    plan_item(12'd1000, 12'd1000, 1'b0, 0, 0, 1'b0);
    plan_item(12'd7,    12'd0,    1'b1, 0, 0, 1'b0);
    // Shorten the burst while one is half collected
    plan_write(REG_EXTRA, 32'd5);
    plan_item(12'd3000, 12'd1000, 1'b0, 0, 0, 1'b0);
    plan_item(12'd3000, 12'd1000, 1'b0, 0, 0, 1'b0);
    plan_item(12'd3000, 12'd1000, 1'b0, 0, 0, 1'b0);
    plan_write(REG_EXTRA, 32'd1);
    plan_item(12'd3000, 12'd1000, 1'b0, 0, 0, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table; registers only change once the core is idle
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_sample(plan[i].raw_x, plan[i].raw_y, plan[i].typed, plan[i].want);
      end
    end

    // Single-sample bursts under a plausible fit
    wait_idle();
    write_reg(REG_EXTRA, 32'd0);
    load_fit();
    run_phase(300, 6);

    // Four-sample bursts
    wait_idle();
    write_reg(REG_EXTRA, 32'd3);
    load_fit();
    run_phase(300, 6);

    // Short bursts, arbitrary weights: mostly off screen
    wait_idle();
    write_reg(REG_EXTRA, $urandom_range(7, 1));
    for (int r = REG_COEF_A; r <= REG_COEF_F; r++) write_reg(REG_IDX_W'(r), $urandom());
    run_phase(200, 6);

    // Longest bursts, pen held down throughout
    wait_idle();
    write_reg(REG_EXTRA, 32'd255);
    load_fit();
    run_phase(520, 0);

    // Back-to-back input into a held-off output: fill the queue, stall the input
    wait_idle();
    write_reg(REG_EXTRA, 32'd0);
    load_fit();
    src_gap_pct = 0;
    hold_req    = 1'b1;
    run_phase(200, 6);

    // Gap-free stretch on both sides
    wait_idle();
    write_reg(REG_EXTRA, 32'd1);
    load_fit();
    sink_stall_pct = 0;
    run_phase(200, 6);

    wait_idle();
    $display("Covered %0d samples and %0d register writes; %0d coordinates checked, %0d with pen down.",
             n_samples, n_writes, n_coords, n_touch);
    $display("Included burst lengths 1 to 256, extreme offsets and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (n_fail == 0 && coord_q.size() == 0) begin
      $display("touch_sample_calibrate_core: match");
    end else begin
      $display("touch_sample_calibrate_core: mismatch");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_front.sv
hw/rtl/tsc_queue.sv
hw/rtl/tsc_back.sv
hw/rtl/touch_sample_calibrate_core.sv
tb/touch_sample_calibrate_core_tb.sv
